// ===== rtl/pclu_pkg.sv =====
// Shared types and constants of the PI current loop duty unit.
package pclu_pkg;

  localparam int ERR_W       = 17;   // setpoint - measured, signed Q8.8
  localparam int MCAND_W     = 18;   // serial multiplicand, signed
  localparam int MPLR_W      = 24;   // serial multiplier, unsigned
  localparam int HI_W        = 21;   // upper product word, signed
  localparam int ADDEND_W    = 17;   // value injected mid-multiply
  localparam int STEP_W      = 5;
  localparam int MUL_STEPS   = 24;
  localparam int INJECT_STEP = 8;    // weight 2^8 lines Q1.16 up with Q.24
  localparam int FRAC_DROP   = 8;
  localparam int Q16_W       = 17;
  localparam int PCT_W       = 7;
  localparam int PRODUCT_W   = 23;   // percent times period
  localparam int DIV_STEPS   = 23;
  localparam int REM_W       = 7;
  localparam int CMP_W       = 16;
  localparam int GAIN_W      = 24;
  localparam int PERIOD_W    = 16;
  localparam int DATA_W      = 32;
  localparam int ADDR_W      = 4;
  localparam int IDX_W       = 2;

  localparam logic [Q16_W-1:0]    ONE_Q16     = 17'd65536;
  localparam logic [Q16_W-1:0]    HALF_Q16    = 17'd32768;
  localparam logic [PCT_W-1:0]    FULL_PCT    = 7'd100;
  localparam logic [PCT_W-1:0]    RESTART_PCT = 7'd50;
  localparam logic [REM_W:0]      DIVISOR     = 8'd100;
  localparam logic [PERIOD_W-1:0] PERIOD_RST  = 16'd65535;

  localparam logic OP_STEP    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [IDX_W-1:0] REG_INTEG_COEF = 2'd1;
  localparam logic [IDX_W-1:0] REG_PWM_PERIOD = 2'd2;

  typedef struct packed {
    logic                   done;
    logic signed [HI_W-1:0] hi;
    logic [MPLR_W-1:0]      lo;
  } smac_res_t;

  typedef struct packed {
    logic             done;
    logic [CMP_W-1:0] quot;
    logic             rem_nz;
  } div_res_t;

endpackage

// ===== rtl/pclu_ifs.sv =====
// Valid/ready channel interfaces for control items and duty results.
interface pclu_in_if;
  logic                     valid;
  logic                     ready;
  logic                     opcode;
  logic signed [15:0]       setpoint;
  logic signed [15:0]       measured_current;

  modport source (output valid, opcode, setpoint, measured_current, input ready);
  modport sink   (input valid, opcode, setpoint, measured_current, output ready);
endinterface

interface pclu_out_if;
  logic                              valid;
  logic                              ready;
  logic [pclu_pkg::PCT_W-1:0]        duty_percent;
  logic [pclu_pkg::CMP_W-1:0]        compare_a;
  logic [pclu_pkg::CMP_W-1:0]        compare_b;

  modport source (output valid, duty_percent, compare_a, compare_b, input ready);
  modport sink   (input valid, duty_percent, compare_a, compare_b, output ready);
endinterface

// ===== rtl/pclu_smac.sv =====
// Bit-serial signed-by-unsigned multiplier with a single mid-run addend.
module pclu_smac (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [pclu_pkg::MCAND_W-1:0]    mcand,
  input  logic [pclu_pkg::MPLR_W-1:0]            mplr,
  input  logic [pclu_pkg::ADDEND_W-1:0]          addend,
  output pclu_pkg::smac_res_t                    res
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [pclu_pkg::STEP_W-1:0]         cnt_r, cnt_nxt;
  logic signed [pclu_pkg::MCAND_W-1:0] mcand_r, mcand_nxt;
  logic [pclu_pkg::ADDEND_W-1:0]       addend_r, addend_nxt;
  logic signed [pclu_pkg::HI_W-1:0]    hi_r, hi_nxt;
  logic [pclu_pkg::MPLR_W-1:0]         lo_r, lo_nxt;
  logic [pclu_pkg::HI_W:0]             part;

  // One multiplier bit per cycle: add, then shift the pair right.
  always_comb begin
    part = (pclu_pkg::HI_W+1)'(hi_r)
         + (lo_r[0] ? (pclu_pkg::HI_W+1)'(mcand_r) : '0)
         + ((cnt_r == pclu_pkg::STEP_W'(pclu_pkg::INJECT_STEP))
            ? (pclu_pkg::HI_W+1)'(addend_r) : '0);
  end

  always_comb begin
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    mcand_nxt  = mcand_r;
    addend_nxt = addend_r;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    if (start) begin
      busy_nxt   = 1'b1;
      cnt_nxt    = '0;
      mcand_nxt  = mcand;
      addend_nxt = addend;
      hi_nxt     = '0;
      lo_nxt     = mplr;
    end else if (busy_r) begin
      hi_nxt  = part[pclu_pkg::HI_W:1];
      lo_nxt  = {part[0], lo_r[pclu_pkg::MPLR_W-1:1]};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == pclu_pkg::STEP_W'(pclu_pkg::MUL_STEPS-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mcand_r  <= mcand_nxt;
    addend_r <= addend_nxt;
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
  end

  assign res.done = done_r;
  assign res.hi   = hi_r;
  assign res.lo   = lo_r;

endmodule

// ===== rtl/pclu_div100.sv =====
// Restoring bit-serial divider by the constant one hundred.
module pclu_div100 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [pclu_pkg::PRODUCT_W-1:0]    dividend,
  output pclu_pkg::div_res_t                res
);

  logic                                busy_r, busy_nxt;
  logic                                done_r, done_nxt;
  logic [pclu_pkg::STEP_W-1:0]         cnt_r, cnt_nxt;
  logic [pclu_pkg::REM_W-1:0]          rem_r, rem_nxt;
  logic [pclu_pkg::PRODUCT_W-1:0]      q_r, q_nxt;
  logic [pclu_pkg::REM_W:0]            trial;
  logic [pclu_pkg::REM_W:0]            diff;
  logic                                ge;

  // Bring down one dividend bit, subtract where it fits.
  always_comb begin
    trial = {rem_r, q_r[pclu_pkg::PRODUCT_W-1]};
    ge    = (trial >= pclu_pkg::DIVISOR);
    diff  = trial - pclu_pkg::DIVISOR;
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      q_nxt    = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[pclu_pkg::REM_W-1:0] : trial[pclu_pkg::REM_W-1:0];
      q_nxt   = {q_r[pclu_pkg::PRODUCT_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == pclu_pkg::STEP_W'(pclu_pkg::DIV_STEPS-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
  end

  assign res.done   = done_r;
  assign res.quot   = q_r[pclu_pkg::CMP_W-1:0];
  assign res.rem_nz = |rem_r;

endmodule

// ===== rtl/pi_current_loop_pwm_duty_unit.sv =====
// Top level of the PI current loop duty unit: control, registers and datapath glue.
// Items are taken only in idle. A step forms its proportional and integral products
// on two 24-bit bit-serial units at once; the proportional unit then scales the
// percent by the period; a 23-step divide by 100 follows. Restarts skip products.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, rst_n low): registers to 0, 0, 65535; integrator one half.
module pi_current_loop_pwm_duty_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  pclu_in_if.sink                           in_ch,
  pclu_out_if.source                        out_ch,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pclu_pkg::ADDR_W-1:0]       paddr,
  input  logic [pclu_pkg::DATA_W-1:0]       pwdata,
  output logic [pclu_pkg::DATA_W-1:0]       prdata,
  output logic                              pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_GAIN  = 3'd1;  // both gain products running
  localparam logic [2:0] ST_PCT   = 3'd2;  // clamp, sum, percent
  localparam logic [2:0] ST_SCALE = 3'd3;  // percent times period
  localparam logic [2:0] ST_DIV   = 3'd4;  // divide by one hundred
  localparam logic [2:0] ST_FIN   = 3'd5;  // hand over to output register

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [pclu_pkg::GAIN_W-1:0]   prop_gain_r, integ_coef_r;
  logic [pclu_pkg::PERIOD_W-1:0] pwm_period_r;
  logic                          cfg_wr;
  logic [pclu_pkg::IDX_W-1:0]    cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[pclu_pkg::ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_coef_r <= '0;
      pwm_period_r <= pclu_pkg::PERIOD_RST;
    end else if (cfg_wr) begin
      // keep the low bits only; an index past the list is dropped
      unique case (cfg_idx)
        pclu_pkg::REG_PROP_GAIN:  prop_gain_r  <= pwdata[pclu_pkg::GAIN_W-1:0];
        pclu_pkg::REG_INTEG_COEF: integ_coef_r <= pwdata[pclu_pkg::GAIN_W-1:0];
        pclu_pkg::REG_PWM_PERIOD: pwm_period_r <= pwdata[pclu_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      pclu_pkg::REG_PROP_GAIN:  prdata = pclu_pkg::DATA_W'(prop_gain_r);
      pclu_pkg::REG_INTEG_COEF: prdata = pclu_pkg::DATA_W'(integ_coef_r);
      pclu_pkg::REG_PWM_PERIOD: prdata = pclu_pkg::DATA_W'(pwm_period_r);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer state and loop state
  // ---------------------------------------------------------------------
  logic [2:0]                           state_r, state_nxt;
  logic                                 restart_r, restart_nxt;
  logic signed [pclu_pkg::ERR_W-1:0]    err_r, err_nxt;
  logic signed [pclu_pkg::ERR_W-1:0]    prev_r, prev_nxt;
  logic [pclu_pkg::Q16_W-1:0]           integ_r, integ_nxt;
  logic [pclu_pkg::PCT_W-1:0]           pct_r, pct_nxt;
  logic                                 out_valid_r, out_valid_nxt;
  logic [pclu_pkg::PCT_W-1:0]           duty_r, duty_nxt;
  logic [pclu_pkg::CMP_W-1:0]           cmp_a_r, cmp_a_nxt;
  logic [pclu_pkg::CMP_W-1:0]           cmp_b_r, cmp_b_nxt;

  logic                                 accept;
  logic                                 restart_in;
  logic signed [pclu_pkg::ERR_W-1:0]    err_in;
  logic signed [pclu_pkg::MCAND_W-1:0]  sum_in;
  logic                                 start_gain;
  logic                                 scale_start;
  logic                                 div_start;
  logic                                 out_load;

  pclu_pkg::smac_res_t                  res_p, res_i;
  pclu_pkg::div_res_t                   res_d;
  logic signed [pclu_pkg::MCAND_W-1:0]  mcand_p;
  logic [pclu_pkg::MPLR_W-1:0]          mplr_p;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign restart_in  = (in_ch.opcode == pclu_pkg::OP_RESTART);

  // Error and trapezoid sum straight from the incoming transaction.
  assign err_in = pclu_pkg::ERR_W'(in_ch.setpoint) - pclu_pkg::ERR_W'(in_ch.measured_current);
  assign sum_in = pclu_pkg::MCAND_W'(err_in) + pclu_pkg::MCAND_W'(prev_r);

  assign start_gain  = accept && !restart_in;
  assign scale_start = (state_r == ST_PCT);
  assign div_start   = (state_r == ST_SCALE) && res_p.done;

  // ---------------------------------------------------------------------
  // Clamp to [0, 1] in Q.24 and drop to Q1.16
  // ---------------------------------------------------------------------
  function automatic logic [pclu_pkg::Q16_W-1:0] clamp_q16(
    input logic signed [pclu_pkg::HI_W-1:0] hi,
    input logic [pclu_pkg::MPLR_W-1:0]      lo
  );
    logic [pclu_pkg::Q16_W-1:0] r;
    if (hi[pclu_pkg::HI_W-1]) begin
      r = '0;
    end else if (hi != '0) begin
      // exactly one or above it: both saturate to one
      r = pclu_pkg::ONE_Q16;
    end else begin
      r = pclu_pkg::Q16_W'(lo[pclu_pkg::MPLR_W-1:pclu_pkg::FRAC_DROP]);
    end
    return r;
  endfunction

  localparam int SUM_W = pclu_pkg::Q16_W + 1;
  localparam int SC_W  = SUM_W + 7;
  localparam int RAW_W = SC_W - 16;

  logic [pclu_pkg::Q16_W-1:0] p16, i16;
  logic [SUM_W-1:0]           duty_sum;
  logic [SC_W-1:0]            scaled;
  logic [RAW_W-1:0]           pct_raw;
  logic [pclu_pkg::PCT_W-1:0] pct_calc;
  logic [pclu_pkg::PCT_W-1:0] pct_sel;

  // Sum of both terms times 100 as shift-adds (64 + 32 + 4), keep the integer part.
  always_comb begin
    p16      = clamp_q16(res_p.hi, res_p.lo);
    i16      = clamp_q16(res_i.hi, res_i.lo);
    duty_sum = SUM_W'(p16) + SUM_W'(i16);
    scaled   = (SC_W'(duty_sum) << 6) + (SC_W'(duty_sum) << 5) + (SC_W'(duty_sum) << 2);
    pct_raw  = scaled[SC_W-1:16];
    pct_calc = (pct_raw > RAW_W'(pclu_pkg::FULL_PCT)) ? pclu_pkg::FULL_PCT
                                                      : pct_raw[pclu_pkg::PCT_W-1:0];
    pct_sel  = restart_r ? pclu_pkg::RESTART_PCT : pct_calc;
  end

  // One serial unit serves the proportional product and later the period scale.
  assign mcand_p = scale_start ? pclu_pkg::MCAND_W'(pct_sel) : pclu_pkg::MCAND_W'(err_in);
  assign mplr_p  = scale_start ? pclu_pkg::MPLR_W'(pwm_period_r) : prop_gain_r;

  pclu_smac u_smac_p (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_gain || scale_start),
    .mcand  (mcand_p),
    .mplr   (mplr_p),
    .addend ('0),
    .res    (res_p)
  );

  // Integral: integ * 256 enters at the ninth step of coef * (err + prev).
  pclu_smac u_smac_i (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start_gain),
    .mcand  (sum_in),
    .mplr   (integ_coef_r),
    .addend (integ_r),
    .res    (res_i)
  );

  pclu_div100 u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (res_p.lo[pclu_pkg::PRODUCT_W-1:0]),
    .res      (res_d)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    restart_nxt   = restart_r;
    err_nxt       = err_r;
    prev_nxt      = prev_r;
    integ_nxt     = integ_r;
    pct_nxt       = pct_r;
    out_valid_nxt = out_valid_r;
    duty_nxt      = duty_r;
    cmp_a_nxt     = cmp_a_r;
    cmp_b_nxt     = cmp_b_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          restart_nxt = restart_in;
          err_nxt     = err_in;
          // restart skips the gain products entirely
          state_nxt   = restart_in ? ST_PCT : ST_GAIN;
        end
      end
      ST_GAIN: begin
        if (res_p.done) begin
          state_nxt = ST_PCT;
        end
      end
      ST_PCT: begin
        pct_nxt   = pct_sel;
        integ_nxt = restart_r ? pclu_pkg::HALF_Q16 : i16;
        prev_nxt  = restart_r ? '0 : err_r;
        state_nxt = ST_SCALE;
      end
      ST_SCALE: begin
        if (res_p.done) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (res_d.done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          // complement: floor((100-d)*P/100) = P - ceil(d*P/100)
          duty_nxt      = pct_r;
          cmp_a_nxt     = res_d.quot;
          cmp_b_nxt     = pwm_period_r - res_d.quot - pclu_pkg::CMP_W'(res_d.rem_nz);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      restart_r   <= 1'b0;
      prev_r      <= '0;
      integ_r     <= pclu_pkg::HALF_Q16;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      restart_r   <= restart_nxt;
      prev_r      <= prev_nxt;
      integ_r     <= integ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload: hold without reset.
  always_ff @(posedge clk) begin
    err_r   <= err_nxt;
    pct_r   <= pct_nxt;
    duty_r  <= duty_nxt;
    cmp_a_r <= cmp_a_nxt;
    cmp_b_r <= cmp_b_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.duty_percent = duty_r;
  assign out_ch.compare_a    = cmp_a_r;
  assign out_ch.compare_b    = cmp_b_r;

endmodule

// ===== rtl/pclu_chk.sv =====
// Port-level assertion checker for the PI current loop duty unit, with its bind.
module pclu_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [pclu_pkg::PCT_W-1:0]  duty_percent,
  input logic [pclu_pkg::CMP_W-1:0]  compare_a,
  input logic [pclu_pkg::CMP_W-1:0]  compare_b
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> duty_percent <= pclu_pkg::FULL_PCT)
    else $error("duty above full scale");

  // both compares follow the percent at the ends and at the midpoint
  a_cmp_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (duty_percent != '0 || compare_a == '0)
               && (duty_percent != pclu_pkg::FULL_PCT || compare_b == '0)
               && (duty_percent != pclu_pkg::RESTART_PCT || compare_a == compare_b))
    else $error("compare values disagree with duty");

  // one transaction in flight at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && in_ready |=> !in_ready)
    else $error("second transaction taken while busy");

endmodule

bind pi_current_loop_pwm_duty_unit pclu_chk u_pclu_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .duty_percent (out_ch.duty_percent),
  .compare_a    (out_ch.compare_a),
  .compare_b    (out_ch.compare_b)
);

// ===== test/pi_current_loop_pwm_duty_unit_checker.sv =====
// Checker for the PI current loop duty unit: duty prediction and result comparison.
`timescale 1ns / 1ps

module pi_current_loop_pwm_duty_unit_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  pclu_in_if                          in_mon,
  pclu_out_if                         out_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [pclu_pkg::ADDR_W-1:0] paddr,
  input  logic [pclu_pkg::DATA_W-1:0] pwdata,
  output int                          fails,
  output int                          results_seen
);

  localparam longint ONE_Q24 = longint'(pclu_pkg::ONE_Q16) << pclu_pkg::FRAC_DROP;

  typedef struct packed {
    logic [pclu_pkg::PCT_W-1:0] pct;
    logic [pclu_pkg::CMP_W-1:0] cmp_a;
    logic [pclu_pkg::CMP_W-1:0] cmp_b;
  } duty_t;

  // Own copy of the register file and loop state
  logic [pclu_pkg::GAIN_W-1:0]          gain_q;
  logic [pclu_pkg::GAIN_W-1:0]          coef_q;
  logic [pclu_pkg::PERIOD_W-1:0]        period_q;
  logic [pclu_pkg::Q16_W-1:0]           integ_acc;
  logic signed [pclu_pkg::ERR_W-1:0]    last_err;

  duty_t duty_due[$];

  initial fails = 0;

  task automatic report_mismatch(input string what, input logic [pclu_pkg::CMP_W-1:0] got,
                                 input logic [pclu_pkg::CMP_W-1:0] want);
    $display("%0t: %s mismatch on result %0d: got %0d, expected %0d",
             $realtime, what, results_seen, got, want);
    fails++;
  endtask

  function automatic longint clamp_unit(input longint v);
    if (v < 0) return 0;
    if (v > ONE_Q24) return ONE_Q24;
    return v;
  endfunction

  function automatic duty_t duty_for_percent(input longint pct);
    duty_t d;
    d.pct   = pclu_pkg::PCT_W'(pct);
    d.cmp_a = pclu_pkg::CMP_W'((pct * longint'(period_q)) / longint'(pclu_pkg::FULL_PCT));
    d.cmp_b = pclu_pkg::CMP_W'(((longint'(pclu_pkg::FULL_PCT) - pct) * longint'(period_q))
                               / longint'(pclu_pkg::FULL_PCT));
    return d;
  endfunction

  // One control step: Q.24 products clamped to [0,1], truncated to Q1.16
  function automatic duty_t duty_after_step(
    input  logic signed [15:0]                 sp,
    input  logic signed [15:0]                 mc,
    output logic [pclu_pkg::Q16_W-1:0]         integ_nx,
    output logic signed [pclu_pkg::ERR_W-1:0]  err_nx
  );
    longint err;
    longint prop;
    longint integ;
    longint pct;
    err   = longint'(sp) - longint'(mc);
    prop  = clamp_unit(longint'(gain_q) * err) >>> pclu_pkg::FRAC_DROP;
    integ = clamp_unit((longint'(integ_acc) << pclu_pkg::FRAC_DROP)
                       + longint'(coef_q) * (err + longint'(last_err)))
            >>> pclu_pkg::FRAC_DROP;
    integ_nx = pclu_pkg::Q16_W'(integ);
    err_nx   = pclu_pkg::ERR_W'(err);
    pct = ((prop + integ) * longint'(pclu_pkg::FULL_PCT)) >>> 16;
    if (pct > longint'(pclu_pkg::FULL_PCT)) pct = longint'(pclu_pkg::FULL_PCT);
    return duty_for_percent(pct);
  endfunction

  always @(posedge clk) begin : watch
    duty_t                             want;
    logic [pclu_pkg::Q16_W-1:0]        integ_nx;
    logic signed [pclu_pkg::ERR_W-1:0] err_nx;
    if (!rst_n) begin
      gain_q    = '0;
      coef_q    = '0;
      period_q  = pclu_pkg::PERIOD_RST;
      integ_acc = pclu_pkg::HALF_Q16;
      last_err  = '0;
      duty_due.delete();
      results_seen <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[pclu_pkg::ADDR_W-1:2])
          pclu_pkg::REG_PROP_GAIN:  gain_q = pwdata[pclu_pkg::GAIN_W-1:0];
          pclu_pkg::REG_INTEG_COEF: coef_q = pwdata[pclu_pkg::GAIN_W-1:0];
          pclu_pkg::REG_PWM_PERIOD: period_q = pwdata[pclu_pkg::PERIOD_W-1:0];
          default: ;  // outside the register list: ignored
        endcase
      end

      if (out_mon.valid && out_mon.ready) begin
        results_seen <= results_seen + 1;
        if (duty_due.size() == 0) begin
          report_mismatch("unrequested duty", pclu_pkg::CMP_W'(out_mon.duty_percent), '0);
        end else begin
          want = duty_due.pop_front();
          if (out_mon.duty_percent !== want.pct)
            report_mismatch("duty_percent", pclu_pkg::CMP_W'(out_mon.duty_percent),
                            pclu_pkg::CMP_W'(want.pct));
          if (out_mon.compare_a !== want.cmp_a)
            report_mismatch("compare_a", out_mon.compare_a, want.cmp_a);
          if (out_mon.compare_b !== want.cmp_b)
            report_mismatch("compare_b", out_mon.compare_b, want.cmp_b);
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.opcode == pclu_pkg::OP_RESTART) begin
          integ_acc = pclu_pkg::HALF_Q16;
          last_err  = '0;
          duty_due.push_back(duty_for_percent(longint'(pclu_pkg::RESTART_PCT)));
        end else begin
          duty_due.push_back(duty_after_step(in_mon.setpoint, in_mon.measured_current,
                                             integ_nx, err_nx));
          integ_acc = integ_nx;
          last_err  = err_nx;
        end
      end
    end
  end

endmodule

// ===== test/pi_current_loop_pwm_duty_unit_tb.sv =====
// Testbench top for the PI current loop duty unit: stimulus, register writes and verdict.
`timescale 1ns / 1ps

module pi_current_loop_pwm_duty_unit_tb;

  localparam int RUN_LIMIT     = 1_500_000;  // cycles before the watchdog gives up
  localparam int SETTLE_CYCLES = 120;        // settle time after the last result is drained
  localparam int HOLD_AT       = 600;        // transactions sent before the long hold-off
  localparam int HOLD_CYCLES   = 900;
  localparam int PHASE_ITEMS   = 230;
  localparam int N_PHASES      = 8;

  // Index just past the register list; writes there must change nothing
  localparam logic [pclu_pkg::IDX_W-1:0] REG_UNUSED = 2'd3;

  logic clk;
  logic rst_n;

  pclu_in_if  in_ch ();
  pclu_out_if out_ch ();

  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [pclu_pkg::ADDR_W-1:0] paddr;
  logic [pclu_pkg::DATA_W-1:0] pwdata;
  logic [pclu_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  int          n_sent;
  int          results_seen;
  int          mismatches;
  logic        quiet;       // no idling on either side while set
  logic        hold_off;    // long receiver stall in progress
  int unsigned cycle_count = 0;

  pi_current_loop_pwm_duty_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  pi_current_loop_pwm_duty_unit_checker chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fails        (mismatches),
    .results_seen (results_seen)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Mostly back-to-back, some short pauses, the odd long one
  function automatic int pick_gap();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 70) return 0;
    if (r < 94) return int'($urandom_range(1, 3));
    return int'($urandom_range(20, 60));
  endfunction

  // Offer one control item and hold it until the block takes it
  task automatic send_item(input logic op, input logic signed [15:0] sp,
                           input logic signed [15:0] mc);
    int gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.opcode           <= op;
    in_ch.setpoint         <= sp;
    in_ch.measured_current <= mc;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
  endtask

  // Mostly a measured current close to the setpoint, sometimes anything at all,
  // with the occasional restart thrown in
  task automatic send_random();
    int                 r;
    logic               op;
    logic signed [15:0] sp;
    logic signed [15:0] mc;
    r  = int'($urandom_range(0, 99));
    op = (r < 5) ? pclu_pkg::OP_RESTART : pclu_pkg::OP_STEP;
    sp = 16'($urandom);
    if (r < 85)
      mc = sp + 16'(int'($urandom_range(0, 1200)) - 600);
    else
      mc = 16'($urandom);
    send_item(op, sp, mc);
  endtask

  // Write: setup, then access; the register takes the value at the access edge
  task automatic write_reg(input logic [pclu_pkg::IDX_W-1:0] idx,
                           input logic [pclu_pkg::DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
  endtask

  task automatic drain();
    while (results_seen != n_sent) @(posedge clk);
  endtask

  // Stop offering, let every result come back, then load a new setting
  task automatic reconfigure(input logic [pclu_pkg::DATA_W-1:0] gain,
                             input logic [pclu_pkg::DATA_W-1:0] coef,
                             input logic [pclu_pkg::DATA_W-1:0] period, input logic calm);
    in_ch.valid <= 1'b0;
    drain();
    write_reg(pclu_pkg::REG_PROP_GAIN, gain);
    write_reg(pclu_pkg::REG_INTEG_COEF, coef);
    write_reg(pclu_pkg::REG_PWM_PERIOD, period);
    write_reg(REG_UNUSED, $urandom);
    psel    <= 1'b0;
    penable <= 1'b0;
    quiet   <= calm;
  endtask

  // Result side: random stalls, none while quiet, solid stall during the hold-off
  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(posedge clk);
      if (hold_off || stall > 0) begin
        out_ch.ready <= 1'b0;
        if (stall > 0) stall--;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
      end else begin
        stall = pick_gap();
        out_ch.ready <= (stall == 0);
        if (stall > 0) stall--;
      end
    end
  end

  // Hold the result side off long enough for the block to fill and stall its input
  initial begin : backpressure
    wait (n_sent >= HOLD_AT);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin : watchdog
    wait (cycle_count >= RUN_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    int                          ph;
    logic [pclu_pkg::DATA_W-1:0] g;
    logic [pclu_pkg::DATA_W-1:0] c;
    logic [pclu_pkg::DATA_W-1:0] p;
    logic                        calm;

    // Known values on every input from time zero
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.opcode           = pclu_pkg::OP_STEP;
    in_ch.setpoint         = '0;
    in_ch.measured_current = '0;
    out_ch.ready           = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    quiet                  = 1'b0;
    hold_off               = 1'b0;
    n_sent                 = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Reset setting: zero gains keep the duty at one half
    send_item(pclu_pkg::OP_STEP, 16'h0000, 16'h0000);
    send_item(pclu_pkg::OP_RESTART, 16'h7FFF, 16'h8000);
    send_item(pclu_pkg::OP_STEP, 16'h7FFF, 16'h8000);

    // Unit gain per ampere: drive both terms into their clamps and back to zero
    reconfigure(32'h0001_0000, 32'h0000_0100, 32'd1000, 1'b0);
    send_item(pclu_pkg::OP_STEP, 16'h7FFF, 16'h8000);
    send_item(pclu_pkg::OP_STEP, 16'h8000, 16'h7FFF);
    send_item(pclu_pkg::OP_STEP, 16'h8000, 16'h7FFF);
    send_item(pclu_pkg::OP_STEP, 16'h0000, 16'h0000);
    send_item(pclu_pkg::OP_STEP, 16'h0100, 16'h0000);
    send_item(pclu_pkg::OP_STEP, 16'h0000, 16'h0080);
    send_item(pclu_pkg::OP_RESTART, 16'h8000, 16'h8000);
    send_item(pclu_pkg::OP_STEP, 16'h5555, 16'h2AAA);

    // Period of zero through a wide write, junk above the gain width
    reconfigure(32'hAB00_4000, 32'h0000_0100, 32'hFFFF_0000, 1'b0);
    send_item(pclu_pkg::OP_RESTART, 16'h0000, 16'h0000);
    send_item(pclu_pkg::OP_STEP, 16'h0064, 16'h0000);
    send_item(pclu_pkg::OP_STEP, 16'hFF9C, 16'h0000);

    // Shortest nonzero period, largest integral gain
    reconfigure(32'h0001_0000, 32'h00FF_FFFF, 32'd1, 1'b0);
    send_item(pclu_pkg::OP_STEP, 16'h0001, 16'h0000);
    send_item(pclu_pkg::OP_STEP, 16'h0000, 16'h0001);
    send_item(pclu_pkg::OP_RESTART, 16'h0000, 16'h0000);
    send_item(pclu_pkg::OP_STEP, 16'h7FFF, 16'h7FFF);

    // Largest proportional gain, longest period
    reconfigure(32'h00FF_FFFF, 32'h0000_0000, 32'd65535, 1'b0);
    send_item(pclu_pkg::OP_STEP, 16'h0001, 16'h0000);
    send_item(pclu_pkg::OP_STEP, 16'h0000, 16'h0001);
    send_item(pclu_pkg::OP_STEP, 16'h8000, 16'h7FFF);

    // Random phases, each under its own setting
    for (ph = 0; ph < N_PHASES; ph++) begin
      calm = 1'b0;
      case (ph)
        0: begin
          g = $urandom_range(0, 1 << 16);
          c = $urandom_range(0, 1 << 10);
          p = $urandom_range(1, 65535);
        end
        1: begin
          g = '0;
          c = 32'h00FF_FFFF;
          p = 32'd65535;
        end
        2: begin
          g = 32'h00FF_FFFF;
          c = '0;
          p = 32'd1;
        end
        3: begin
          g = $urandom;
          c = $urandom;
          p = $urandom;
        end
        4: begin
          g = $urandom_range(0, 1 << 15);
          c = $urandom_range(0, 1 << 9);
          p = 32'd100;
          calm = 1'b1;
        end
        5: begin
          g = $urandom_range(0, 1 << 14);
          c = $urandom_range(0, 1 << 8);
          p = 32'h0001_0000;
        end
        6: begin
          g = $urandom_range(0, 1 << 17);
          c = $urandom_range(0, 1 << 12);
          p = {16'($urandom), 16'($urandom_range(1, 65535))};
        end
        default: begin
          g = $urandom_range(0, 1 << 18);
          c = $urandom_range(0, 1 << 14);
          p = 32'd65535;
        end
      endcase
      reconfigure(g, c, p, calm);
      repeat (PHASE_ITEMS) send_random();
    end

    // Drop valid, collect the rest, then give stray results time to show
    in_ch.valid <= 1'b0;
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
